>>> hdl/dqzz_pkg.sv
// dqzz_pkg: shared constants and types of the dequantizer / de-zigzag block
// zig-zag to raster map, block and queue sizes, buffer write record
// no dependencies
package dqzz_pkg;

	localparam int BLOCK_SIZE  = 64;
	localparam int BLOCK_AW    = 6;
	localparam int VALUE_W     = 16;
	localparam int QUANT_W     = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [BLOCK_AW-1:0] LAST_POS = 6'd63;

	// raster position of each zig-zag position
	localparam logic [BLOCK_AW-1:0] ZZ_TO_RASTER [BLOCK_SIZE] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [BLOCK_AW-1:0] raster;
		logic                last;
	} buf_write_t;

	typedef struct packed {
		logic       valid;
		buf_write_t data;
	} buf_push_t;

endpackage

>>> hdl/dqzz_if.sv
// dqzz_coef_if / dqzz_res_if: valid/ready channels of the block
// input items (table writes and coefficients) and raster ordered results
// no dependencies
interface dqzz_coef_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [1:0]         table_select;
	logic [5:0]         table_index;
	logic [7:0]         quant_value;
	logic signed [15:0] coef_value;

	modport source (output valid, func, table_select, table_index, quant_value, coef_value,
		input ready);
	modport sink (input valid, func, table_select, table_index, quant_value, coef_value,
		output ready);
endinterface

interface dqzz_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_value;
	logic [5:0]         raster_index;
	logic               last;

	modport source (output valid, out_value, raster_index, last, input ready);
	modport sink (input valid, out_value, raster_index, last, output ready);
endinterface

>>> hdl/dqzz_front.sv
// dqzz_front: accepts items, keeps the quantization tables, multiplies
// coefficients by their step and pushes raster addressed buffer writes
// depends on dqzz_pkg, dqzz_if
module dqzz_front #(
	parameter int NUM_TABLES = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dqzz_coef_if.sink                    coef,
	input  logic [dqzz_pkg::QUEUE_AW:0]  queue_count,
	output dqzz_pkg::buf_push_t          push
);

	localparam int QDEPTH  = NUM_TABLES * dqzz_pkg::BLOCK_SIZE;
	localparam int QADDR_W = $clog2(QDEPTH);

	logic [dqzz_pkg::QUANT_W-1:0] qmem [QDEPTH];

	logic                          accept;
	logic                          sel_ok;
	logic [7:0]                    waddr_full;
	logic [7:0]                    raddr_full;
	logic [dqzz_pkg::BLOCK_AW-1:0] coef_cnt_q;

	logic                          valid_s1;
	logic                          selok_s1;
	logic [dqzz_pkg::BLOCK_AW-1:0] pos_s1;
	logic [15:0]                   coef_s1;
	logic [dqzz_pkg::QUANT_W-1:0]  quant_rd_s1;

	logic [dqzz_pkg::QUANT_W-1:0]  step;
	logic [23:0]                   prod;
	logic [dqzz_pkg::QUEUE_AW+1:0] in_flight;

	assign in_flight  = {1'b0, queue_count} + {{(dqzz_pkg::QUEUE_AW+1){1'b0}}, valid_s1};
	assign coef.ready = in_flight < (dqzz_pkg::QUEUE_AW+2)'(dqzz_pkg::QUEUE_DEPTH);
	assign accept     = coef.valid && coef.ready;
	assign sel_ok     = {1'b0, coef.table_select} < 3'(NUM_TABLES);
	assign waddr_full = {coef.table_select, coef.table_index};
	assign raddr_full = {coef.table_select, coef_cnt_q};

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && !coef.func && sel_ok) begin
			qmem[waddr_full[QADDR_W-1:0]] <= coef.quant_value;
		end
		if (accept && coef.func) begin
			quant_rd_s1 <= qmem[raddr_full[QADDR_W-1:0]];
			coef_s1     <= coef.coef_value;
			pos_s1      <= coef_cnt_q;
			selok_s1    <= sel_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			coef_cnt_q <= '0;
		end else begin
			valid_s1 <= accept && coef.func;
			if (accept && coef.func) begin
				coef_cnt_q <= coef_cnt_q + 1'b1;
			end
		end
	end

	assign step = selok_s1 ? quant_rd_s1 : '0;
	assign prod = {8'b0, coef_s1} * {16'b0, step};

	always_comb begin
		push.valid       = valid_s1;
		push.data.value  = prod[dqzz_pkg::VALUE_W-1:0];
		push.data.raster = dqzz_pkg::ZZ_TO_RASTER[pos_s1];
		push.data.last   = pos_s1 == dqzz_pkg::LAST_POS;
	end

endmodule

>>> hdl/dqzz_queue.sv
// dqzz_queue: short fifo of buffer writes between front and back
// depends on dqzz_pkg
module dqzz_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dqzz_pkg::buf_push_t          push,
	input  logic                         pop,
	output dqzz_pkg::buf_push_t          head,
	output logic [dqzz_pkg::QUEUE_AW:0]  count
);

	dqzz_pkg::buf_write_t           entries [dqzz_pkg::QUEUE_DEPTH];
	logic [dqzz_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [dqzz_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [dqzz_pkg::QUEUE_AW:0]    cnt_q;
	logic                           do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = cnt_q != '0;
	assign head.data  = entries[rd_ptr_q];
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{dqzz_pkg::QUEUE_AW{1'b0}}, push.valid}
				- {{dqzz_pkg::QUEUE_AW{1'b0}}, do_pop};
		end
	end

endmodule

>>> hdl/dqzz_back.sv
// dqzz_back: block buffer fill from the queue and raster order drain
// two entry output fifo after the registered buffer read
// depends on dqzz_pkg, dqzz_if
module dqzz_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dqzz_pkg::buf_push_t head,
	output logic                pop,
	dqzz_res_if.source          result
);

	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic [dqzz_pkg::VALUE_W-1:0]  bmem [dqzz_pkg::BLOCK_SIZE];

	logic                          state_q;
	logic [dqzz_pkg::BLOCK_AW-1:0] rd_addr_q;
	logic                          pend_s1;
	logic [dqzz_pkg::BLOCK_AW-1:0] pend_idx_s1;
	logic [dqzz_pkg::VALUE_W-1:0]  rd_data_s1;

	logic [dqzz_pkg::VALUE_W-1:0]  oval_q [2];
	logic [dqzz_pkg::BLOCK_AW-1:0] oidx_q [2];
	logic                          owr_q;
	logic                          ord_q;
	logic [1:0]                    ocnt_q;

	logic                          out_pop;
	logic [2:0]                    occ;
	logic                          issue;

	assign pop     = (state_q == ST_FILL) && head.valid;
	assign out_pop = result.valid && result.ready;
	assign occ     = {1'b0, ocnt_q} + {2'b0, pend_s1};
	assign issue   = (state_q == ST_DRAIN) && ((occ < 3'd2) || ((occ == 3'd2) && out_pop));

	assign result.valid        = ocnt_q != 2'd0;
	assign result.out_value    = oval_q[ord_q];
	assign result.raster_index = oidx_q[ord_q];
	assign result.last         = oidx_q[ord_q] == dqzz_pkg::LAST_POS;

	// block buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (pop) begin
			bmem[head.data.raster] <= head.data.value;
		end
		if (issue) begin
			rd_data_s1  <= bmem[rd_addr_q];
			pend_idx_s1 <= rd_addr_q;
		end
		if (pend_s1) begin
			oval_q[owr_q] <= rd_data_s1;
			oidx_q[owr_q] <= pend_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			rd_addr_q <= '0;
			pend_s1   <= 1'b0;
			owr_q     <= 1'b0;
			ord_q     <= 1'b0;
			ocnt_q    <= 2'd0;
		end else begin
			pend_s1 <= issue;
			case (state_q)
				ST_FILL: begin
					if (pop && head.data.last) begin
						state_q   <= ST_DRAIN;
						rd_addr_q <= '0;
					end
				end
				ST_DRAIN: begin
					if (issue) begin
						rd_addr_q <= rd_addr_q + 1'b1;
						if (rd_addr_q == dqzz_pkg::LAST_POS) begin
							state_q <= ST_FILL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
			if (pend_s1) begin
				owr_q <= ~owr_q;
			end
			if (out_pop) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, pend_s1} - {1'b0, out_pop};
		end
	end

endmodule

>>> hdl/jpeg_dequant_dezigzag.sv
// jpeg_dequant_dezigzag: top level of the 8x8 dequantizer and inverse zig-zag
// depends on dqzz_pkg, dqzz_if, dqzz_front, dqzz_queue, dqzz_back
//
// coef channel: table writes (func 0) load one step of a quantization table;
// coefficients (func 1) arrive in zig-zag order with a table select
// result channel: after the 64th coefficient of a block, 64 dequantized values
// in raster order, last set on raster index 63
// the front takes one item per cycle while the four entry queue has room; a
// coefficient passes the front read register and the queue on its way to the
// block buffer
// the first result follows the 64th coefficient through the queue, the buffer read
// and the output fifo; then one result per cycle while the receiver takes them
// while a block drains the buffer is read and the queue is not emptied, so the
// front stalls once four coefficients of the next block wait
// a stalled receiver holds the result and backs up the drain and then the input
// reset clears counters, queue and drain state; tables and buffer hold
// whatever was last written
module jpeg_dequant_dezigzag #(
	parameter int NUM_TABLES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	dqzz_coef_if.sink  coef,
	dqzz_res_if.source result
);

	dqzz_pkg::buf_push_t          push;
	dqzz_pkg::buf_push_t          head;
	logic                         pop;
	logic [dqzz_pkg::QUEUE_AW:0]  queue_count;

	dqzz_front #(
		.NUM_TABLES(NUM_TABLES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (coef),
		.queue_count (queue_count),
		.push        (push)
	);

	dqzz_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (queue_count)
	);

	dqzz_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

>>> hdl/dqzz_checker.sv
// dqzz_checker: port level checks of the result channel
// bound to jpeg_dequant_dezigzag; depends on nothing else
module dqzz_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] res_value,
	input logic [5:0]  res_raster,
	input logic        res_last
);

	logic [5:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (res_valid && res_ready) begin
			exp_idx_q <= res_raster + 1'b1;
		end
	end

	// results of a block come in raster order starting at zero
	a_raster_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> res_raster == exp_idx_q)
		else $error("result raster index out of order");

	// last marks exactly the final raster position
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_last == (res_raster == 6'd63))
		else $error("last flag does not match raster index");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_raster))
		else $error("result changed while stalled");

endmodule

bind jpeg_dequant_dezigzag dqzz_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_value  (result.out_value),
	.res_raster (result.raster_index),
	.res_last   (result.last)
);
